### rtl/core/ftc_pkg.sv
// Flight termination controller package: payload and configuration types,
// mode and register codes, reset values. No dependencies.
package ftc_pkg;

	localparam int ELAPSED_BITS = 16;
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};
	localparam int SECONDS_PER_MINUTE = 60;

	localparam int ADDR_BITS = 5;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_GROUND_PRESSURE = 3'd0;
	localparam logic [2:0] REG_ARM_DELTA       = 3'd1;
	localparam logic [2:0] REG_CUT_PRESSURE    = 3'd2;
	localparam logic [2:0] REG_CUT_MINUTES     = 3'd3;
	localparam logic [2:0] REG_BURN_SECONDS    = 3'd4;
	localparam logic [2:0] REG_CHECK_PERIOD    = 3'd5;

	// flight modes
	localparam logic [1:0] MODE_DISARMED = 2'd0;
	localparam logic [1:0] MODE_ARMED    = 2'd1;
	localparam logic [1:0] MODE_BURNING  = 2'd2;
	localparam logic [1:0] MODE_COMPLETE = 2'd3;

	// cause flag bit positions
	localparam int CAUSE_TIME     = 0;
	localparam int CAUSE_PRESSURE = 1;
	localparam int CAUSE_REMOTE   = 2;
	localparam int CAUSE_EXTERNAL = 3;
	localparam int CAUSE_NATURAL  = 4;

	localparam logic [14:0] RST_GROUND_PRESSURE = 15'd16212;
	localparam logic [9:0]  RST_ARM_DELTA       = 10'd10;
	localparam logic [10:0] RST_CUT_PRESSURE    = 11'd10;
	localparam logic [7:0]  RST_CUT_MINUTES     = 8'd120;
	localparam logic [7:0]  RST_BURN_SECONDS    = 8'd30;
	localparam logic [7:0]  RST_CHECK_PERIOD    = 8'd10;

	typedef struct packed {
		logic [14:0] ground_pressure;
		logic [9:0]  arm_delta_hpa;
		logic [10:0] cut_pressure_hpa;
		logic [7:0]  cut_minutes;
		logic [7:0]  burn_seconds;
		logic [7:0]  check_period;
	} ftc_cfg_t;

	typedef struct packed {
		logic [14:0] pressure;
		logic        remote_cmd;
		logic        external_cut;
	} ftc_in_t;

	typedef struct packed {
		logic [1:0]  flight_state;
		logic        hotwire_on;
		logic        error_led;
		logic [15:0] elapsed_seconds;
		logic [4:0]  cause_flags;
	} ftc_out_t;

endpackage

### rtl/core/ftc_regs.sv
// Configuration register file behind an APB-style port.
// Depends on ftc_pkg.
module ftc_regs import ftc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output ftc_cfg_t             cfg
);

	ftc_cfg_t   cfg_q;
	logic [2:0] index;
	logic       wr_en;

	assign index  = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ground_pressure  <= RST_GROUND_PRESSURE;
			cfg_q.arm_delta_hpa    <= RST_ARM_DELTA;
			cfg_q.cut_pressure_hpa <= RST_CUT_PRESSURE;
			cfg_q.cut_minutes      <= RST_CUT_MINUTES;
			cfg_q.burn_seconds     <= RST_BURN_SECONDS;
			cfg_q.check_period     <= RST_CHECK_PERIOD;
		end else if (wr_en) begin
			unique case (index)
				REG_GROUND_PRESSURE: cfg_q.ground_pressure  <= pwdata[14:0];
				REG_ARM_DELTA:       cfg_q.arm_delta_hpa    <= pwdata[9:0];
				REG_CUT_PRESSURE:    cfg_q.cut_pressure_hpa <= pwdata[10:0];
				REG_CUT_MINUTES:     cfg_q.cut_minutes      <= pwdata[7:0];
				REG_BURN_SECONDS:    cfg_q.burn_seconds     <= pwdata[7:0];
				REG_CHECK_PERIOD:    cfg_q.check_period     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_GROUND_PRESSURE: prdata = 32'(cfg_q.ground_pressure);
			REG_ARM_DELTA:       prdata = 32'(cfg_q.arm_delta_hpa);
			REG_CUT_PRESSURE:    prdata = 32'(cfg_q.cut_pressure_hpa);
			REG_CUT_MINUTES:     prdata = 32'(cfg_q.cut_minutes);
			REG_BURN_SECONDS:    prdata = 32'(cfg_q.burn_seconds);
			REG_CHECK_PERIOD:    prdata = 32'(cfg_q.check_period);
			default:             prdata = 32'd0;
		endcase
	end

endmodule

### rtl/core/flight_termination_controller.sv
// Flight termination controller top level: tick processing and result register.
// Depends on ftc_pkg and ftc_regs.

// Each word on the sample channel is one one-second tick and yields exactly
// one result word showing the flight state after that tick. The state update
// and the result for a tick are computed in one pass of logic and land in the
// state registers and the result register at the accepting edge, so a new
// sample is taken every cycle while the result register is empty or being
// drained. The block arms once the pressure falls more than arm_delta_hpa
// below ground_pressure, then checks its cut conditions every check_period
// ticks (every tick when check_period is zero), burns the hot wire for
// burn_seconds ticks on a cut and stays complete until reset. Write registers
// only while no result is pending.
module flight_termination_controller import ftc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  ftc_in_t              sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ftc_out_t             result
);

	ftc_cfg_t cfg;

	ftc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [1:0]              mode_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [14:0]             lowest_q;
	logic [7:0]              check_count_q;
	logic [7:0]              burn_left_q;
	logic                    result_valid_q;
	ftc_out_t                result_q;

	logic [1:0]              mode_d;
	logic [ELAPSED_BITS-1:0] elapsed_d;
	logic [14:0]             lowest_d;
	logic [7:0]              check_count_d;
	logic [7:0]              burn_left_d;
	logic [4:0]              causes;
	logic                    accept;

	logic [13:0] arm16;
	logic [14:0] ground_diff;
	logic [7:0]  period;
	logic [7:0]  count_inc;
	logic [14:0] lowest_min;
	logic [13:0] cut_time;
	logic [14:0] cut_p16;
	logic [16:0] natural_limit;
	logic [31:0] elapsed_wide;

	assign sample_ready = !result_valid_q || result_ready;
	assign accept       = sample_valid && sample_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign arm16         = {cfg.arm_delta_hpa, 4'b0000};
	assign ground_diff   = cfg.ground_pressure - sample.pressure;
	assign period        = (cfg.check_period == 8'd0) ? 8'd1 : cfg.check_period;
	assign count_inc     = check_count_q + 8'd1;
	assign lowest_min    = (sample.pressure < lowest_q) ? sample.pressure : lowest_q;
	assign cut_time      = 14'(cfg.cut_minutes) * 14'(SECONDS_PER_MINUTE);
	assign cut_p16       = {cfg.cut_pressure_hpa, 4'b0000};
	assign natural_limit = 17'(lowest_min) + 17'({arm16, 1'b0});
	assign elapsed_wide  = 32'(elapsed_d);

	always_comb begin
		mode_d        = mode_q;
		lowest_d      = lowest_q;
		check_count_d = check_count_q;
		burn_left_d   = burn_left_q;
		causes        = 5'd0;

		if (mode_q != MODE_DISARMED) begin
			elapsed_d = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		end else begin
			elapsed_d = '0;
		end

		unique case (mode_q)
			MODE_DISARMED: begin
				if (cfg.ground_pressure > sample.pressure && ground_diff > 15'(arm16)) begin
					mode_d        = MODE_ARMED;
					check_count_d = 8'd0;
				end
			end
			MODE_ARMED: begin
				check_count_d = count_inc;
				if (count_inc >= period) begin
					check_count_d = 8'd0;
					lowest_d      = lowest_min;
					causes[CAUSE_TIME]     = elapsed_wide >= 32'(cut_time);
					causes[CAUSE_PRESSURE] = sample.pressure < cut_p16;
					causes[CAUSE_REMOTE]   = sample.remote_cmd;
					causes[CAUSE_EXTERNAL] = sample.external_cut;
					causes[CAUSE_NATURAL]  = 17'(sample.pressure) > natural_limit;
					// a cut wins over natural end
					if (causes[3:0] != 4'd0) begin
						if (cfg.burn_seconds == 8'd0) begin
							mode_d = MODE_COMPLETE;
						end else begin
							mode_d      = MODE_BURNING;
							burn_left_d = cfg.burn_seconds;
						end
					end else if (causes[CAUSE_NATURAL]) begin
						mode_d = MODE_COMPLETE;
					end
				end
			end
			MODE_BURNING: begin
				if (burn_left_q != 8'd0) begin
					burn_left_d = burn_left_q - 8'd1;
				end
				if (burn_left_d == 8'd0) begin
					mode_d = MODE_COMPLETE;
				end
			end
			MODE_COMPLETE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_DISARMED;
			elapsed_q      <= '0;
			lowest_q       <= '1;
			check_count_q  <= 8'd0;
			burn_left_q    <= 8'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q         <= mode_d;
				elapsed_q      <= elapsed_d;
				lowest_q       <= lowest_d;
				check_count_q  <= check_count_d;
				burn_left_q    <= burn_left_d;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.flight_state    <= mode_d;
			result_q.hotwire_on      <= (mode_d == MODE_BURNING);
			result_q.error_led       <= (mode_d == MODE_COMPLETE);
			result_q.elapsed_seconds <= (elapsed_wide > 32'h0000_FFFF) ? 16'hFFFF
				: elapsed_wide[15:0];
			result_q.cause_flags     <= causes;
		end
	end

	a_complete_final: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_COMPLETE |=> mode_q == MODE_COMPLETE)
		else $error("complete state left without reset");

	a_disarmed_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DISARMED |-> elapsed_q == '0)
		else $error("elapsed time running while disarmed");

	a_hotwire_burning: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.hotwire_on == (result.flight_state == MODE_BURNING))
		else $error("hot wire out of step with flight state");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !sample_ready)
		else $error("sample taken while result stalled");

endmodule
